// ----- hw/rtl/ps2mt_pkg.sv -----
// Shared types and constants for the mouse packet tracker.
// Holds the beat structs, register indexes and field widths; depends on nothing.
package ps2mt_pkg;

    localparam int REG_W     = 13;
    localparam int OUT_W     = 12;
    localparam int DELTA_W   = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    localparam logic [REG_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [REG_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

    localparam int RESET_POS  = 100;
    localparam int SYNC_BIT   = 3;
    localparam int XSIGN_BIT  = 4;
    localparam int YSIGN_BIT  = 5;
    localparam int LEFT_BIT   = 0;

    typedef struct packed {
        logic       aux_ready;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic [OUT_W-1:0] cursor_x;
        logic [OUT_W-1:0] cursor_y;
        logic             left_button;
    } t_out_beat;

endpackage

// ----- hw/rtl/ps2mt_clamp.sv -----
// Coordinate update for one axis: apply a 9-bit signed delta and clamp to the screen.
// Depends on ps2mt_pkg for register and delta widths.
module ps2mt_clamp #(
    parameter int COORD_BITS  = 12,
    parameter int CURSOR_SIZE = 16
) (
    input  logic [COORD_BITS-1:0]             i_pos,
    input  logic [ps2mt_pkg::DELTA_W-1:0]     i_delta,
    input  logic                              i_sub,
    input  logic [ps2mt_pkg::REG_W-1:0]       i_screen,
    output logic [COORD_BITS-1:0]             o_pos
);
    import ps2mt_pkg::*;

    localparam int SW = ((COORD_BITS > REG_W) ? COORD_BITS : REG_W) + 2;
    localparam logic signed [SW-1:0] CMAX = SW'((1 << COORD_BITS) - 1);
    localparam logic signed [SW-1:0] CSZ  = SW'(CURSOR_SIZE);

    logic signed [SW-1:0] s_pos;
    logic signed [SW-1:0] s_delta;
    logic signed [SW-1:0] s_sum;
    logic signed [SW-1:0] s_lim_raw;
    logic signed [SW-1:0] s_lim;
    logic signed [SW-1:0] s_res;

    always_comb begin
        s_pos     = $signed({{(SW-COORD_BITS){1'b0}}, i_pos});
        s_delta   = $signed({{(SW-DELTA_W){i_delta[DELTA_W-1]}}, i_delta});
        s_sum     = i_sub ? (s_pos - s_delta) : (s_pos + s_delta);
        s_lim_raw = $signed({{(SW-REG_W){1'b0}}, i_screen}) - CSZ;
        if (s_lim_raw > CMAX) begin
            s_lim = CMAX;
        end else if (s_lim_raw < 0) begin
            s_lim = '0;
        end else begin
            s_lim = s_lim_raw;
        end
        if (s_sum < 0) begin
            s_res = '0;
        end else if (s_sum > s_lim) begin
            s_res = s_lim;
        end else begin
            s_res = s_sum;
        end
        o_pos = s_res[COORD_BITS-1:0];
    end

endmodule

// ----- hw/rtl/ps2_mouse_packet_tracker.sv -----
// Three-byte mouse packet decoder with clamped cursor tracking.
// Throughput: one byte per cycle, except while a completed packet waits on a stalled result beat.
// Each byte is registered, then decoded against the packet state into the result register.
// Reset (synchronous, active low) returns to header search, cursor at (100,100),
// screen 640x480. Depends on ps2mt_pkg and ps2mt_clamp.
module ps2_mouse_packet_tracker #(
    parameter int COORD_BITS  = 12,
    parameter int CURSOR_SIZE = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ps2mt_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [ps2mt_pkg::REG_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ps2mt_pkg::t_in_beat               i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ps2mt_pkg::t_out_beat              o_out_data
);
    import ps2mt_pkg::*;

    typedef enum logic [1:0] {
        PH_HEAD  = 2'd0,
        PH_XDATA = 2'd1,
        PH_YDATA = 2'd2
    } t_phase;

    logic [REG_W-1:0]      r_screen_w;
    logic [REG_W-1:0]      r_screen_h;
    logic                  r_in_valid;
    t_in_beat              r_in;
    t_phase                r_phase;
    t_phase                n_phase;
    logic [7:0]            r_header;
    logic [7:0]            r_xbyte;
    logic [COORD_BITS-1:0] r_pos_x;
    logic [COORD_BITS-1:0] r_pos_y;
    logic                  r_out_valid;
    t_out_beat             r_out;

    logic                  s_done;
    logic                  s_adv;
    logic                  s_take;
    logic [DELTA_W-1:0]    s_dx;
    logic [DELTA_W-1:0]    s_dy;
    logic [COORD_BITS-1:0] s_new_x;
    logic [COORD_BITS-1:0] s_new_y;

    assign s_done     = r_in_valid && r_in.aux_ready && (r_phase == PH_YDATA);
    assign s_adv      = r_in_valid && (!s_done || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !s_adv;
    assign s_take     = i_in_valid && !o_in_stall;

    assign s_dx = {r_header[XSIGN_BIT], r_xbyte};
    assign s_dy = {r_header[YSIGN_BIT], r_in.data_byte};

    ps2mt_clamp #(.COORD_BITS(COORD_BITS), .CURSOR_SIZE(CURSOR_SIZE)) u_clamp_x (
        .i_pos    (r_pos_x),
        .i_delta  (s_dx),
        .i_sub    (1'b0),
        .i_screen (r_screen_w),
        .o_pos    (s_new_x)
    );

    ps2mt_clamp #(.COORD_BITS(COORD_BITS), .CURSOR_SIZE(CURSOR_SIZE)) u_clamp_y (
        .i_pos    (r_pos_y),
        .i_delta  (s_dy),
        .i_sub    (1'b1),
        .i_screen (r_screen_h),
        .o_pos    (s_new_y)
    );

    always_comb begin
        n_phase = r_phase;
        if (r_in.aux_ready) begin
            case (r_phase)
                PH_XDATA: n_phase = PH_YDATA;
                PH_YDATA: n_phase = PH_HEAD;
                default:  n_phase = r_in.data_byte[SYNC_BIT] ? PH_XDATA : PH_HEAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= SCREEN_WIDTH_RST;
            r_screen_h <= SCREEN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_take) begin
            r_in_valid <= 1'b1;
        end else if (s_adv) begin
            r_in_valid <= 1'b0;
        end
        if (s_take) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEAD;
            r_header    <= '0;
            r_xbyte     <= '0;
            r_pos_x     <= COORD_BITS'(RESET_POS);
            r_pos_y     <= COORD_BITS'(RESET_POS);
            r_out_valid <= 1'b0;
        end else begin
            if (s_adv) begin
                r_phase <= n_phase;
                if (r_in.aux_ready && r_phase == PH_XDATA) begin
                    r_xbyte <= r_in.data_byte;
                end
                if (r_in.aux_ready && r_phase != PH_XDATA && r_phase != PH_YDATA
                        && r_in.data_byte[SYNC_BIT]) begin
                    r_header <= r_in.data_byte;
                end
            end
            if (s_adv && s_done) begin
                r_pos_x     <= s_new_x;
                r_pos_y     <= s_new_y;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv && s_done) begin
            r_out.cursor_x    <= OUT_W'(s_new_x);
            r_out.cursor_y    <= OUT_W'(s_new_y);
            r_out.left_button <= r_header[LEFT_BIT];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_done_to_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && s_done |=> r_phase == PH_HEAD)
        else $error("packet completion did not return to header search");

    a_out_from_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s_adv && s_done))
        else $error("result beat raised without a completed packet");

    a_non_aux_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && !r_in.aux_ready |=> $stable(r_phase) && $stable(r_pos_x)
            && $stable(r_pos_y))
        else $error("non-aux byte changed tracker state");

endmodule
